// ===== rtl/alarm_table_expiry_core_assert.svh =====
// assertion macros shared by the alarm table rtl
// expects clk and arst_n in the scope of each use
`ifndef ALARM_TABLE_EXPIRY_CORE_ASSERT_SVH
`define ALARM_TABLE_EXPIRY_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ATE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ATE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ate_pkg.sv =====
`timescale 1ns / 1ps
// types, codes and sizing constants of the alarm table
// used by every rtl module of the block, depends on nothing
package ate_pkg;

	localparam int NUM_ALARMS = 16;
	localparam int TICK_WIDTH = 32;
	localparam int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
	localparam int SUM_W      = ((TICK_WIDTH > 32) ? TICK_WIDTH : 32) + 1;
	localparam int CMP_W      = (TICK_WIDTH > 32) ? TICK_WIDTH : 32;
	localparam int CFG_IDX_W  = 1;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	typedef logic [TICK_WIDTH-1:0] tick_t;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_SET_REL = 3'd1,
		OP_SET_ABS = 3'd2,
		OP_CANCEL  = 3'd3,
		OP_QUERY   = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_ALLOWED = 1'b0,
		CFG_MIN_CYCLE   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_BAD_ID = 2'd1,
		STS_LIMIT  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RK_RESP = 2'd0,
		RK_FIRE = 2'd1,
		RK_DONE = 2'd2
	} result_kind_t;

	// what the back end has to do; rejected and unknown ops only answer
	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_SET_REL = 3'd1,
		CMD_SET_ABS = 3'd2,
		CMD_CANCEL  = 3'd3,
		CMD_QUERY   = 3'd4,
		CMD_RESPOND = 3'd5
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		status_t          status;
		logic [IDX_W-1:0] idx;
		logic [31:0]      arg;    // tick value or time value
		logic [31:0]      cycle;
	} cmd_t;

	function automatic tick_t to_tick(input logic [31:0] v);
		return TICK_WIDTH'(v);
	endfunction

endpackage

// ===== rtl/ate_front.sv =====
`timescale 1ns / 1ps
// front end: configuration registers, input transfer and operation checks
// depends on ate_pkg; feeds ate_cmd_fifo
module ate_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [ate_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    operation,
	input  logic [7:0]                    alarm_index,
	input  logic [31:0]                   tick_value,
	input  logic [31:0]                   time_value,
	input  logic [31:0]                   cycle_ticks,
	input  logic                          q_full,
	output logic                          q_push,
	output ate_pkg::cmd_t                 q_data,
	output logic [31:0]                   max_allowed
);
	import ate_pkg::*;

	logic [31:0] max_allowed_q;
	logic [31:0] min_cycle_q;
	logic        bad_id;
	logic        limit_hit;
	op_t         op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_allowed_q <= '1;
			min_cycle_q   <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_MAX_ALLOWED: max_allowed_q <= cfg_data;
				CFG_MIN_CYCLE:   min_cycle_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign max_allowed = max_allowed_q;
	assign in_ready    = !q_full;
	assign q_push      = in_valid && !q_full;

	assign op        = op_t'(operation);
	assign bad_id    = alarm_index >= 8'(NUM_ALARMS);
	// a zero cycle is a one-shot and skips the minimum check
	assign limit_hit = (time_value > max_allowed_q) ||
	                   ((cycle_ticks != '0) && (cycle_ticks < min_cycle_q));

	always_comb begin
		q_data.kind   = CMD_RESPOND;
		q_data.status = STS_OK;
		q_data.idx    = IDX_W'(alarm_index);
		q_data.arg    = time_value;
		q_data.cycle  = cycle_ticks;
		case (op)
			OP_TICK: begin
				q_data.kind = CMD_TICK;
				q_data.arg  = tick_value;
			end
			OP_SET_REL, OP_SET_ABS: begin
				if (bad_id) begin
					q_data.status = STS_BAD_ID;
				end else if (limit_hit) begin
					q_data.status = STS_LIMIT;
				end else begin
					q_data.kind = (op == OP_SET_REL) ? CMD_SET_REL : CMD_SET_ABS;
				end
			end
			OP_CANCEL: begin
				if (bad_id) q_data.status = STS_BAD_ID;
				else q_data.kind = CMD_CANCEL;
			end
			OP_QUERY: begin
				if (bad_id) q_data.status = STS_BAD_ID;
				else q_data.kind = CMD_QUERY;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/ate_cmd_fifo.sv =====
`timescale 1ns / 1ps
// short command queue between front and back end
// depends on ate_pkg and the assertion macro header
`include "alarm_table_expiry_core_assert.svh"
module ate_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ate_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output ate_pkg::cmd_t pop_data,
	output logic          empty
);
	import ate_pkg::*;

	cmd_t                  entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;

	assign full     = count_q == CMDQ_CNT_W'(CMDQ_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`ATE_ASSERT_NOW(a_no_push_full, push, !full, "push into full command queue")
	`ATE_ASSERT_NOW(a_no_pop_empty, pop, !empty, "pop from empty command queue")
	`ATE_ASSERT_NEXT(a_cnt_up, (push && !pop), (count_q == $past(count_q) + 1'b1), "queue count lost a push")

endmodule

// ===== rtl/ate_back.sv =====
`timescale 1ns / 1ps
// back end: alarm slot table, tick scan sequencer and result register
// depends on ate_pkg and the assertion macro header
`include "alarm_table_expiry_core_assert.svh"
module ate_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  ate_pkg::cmd_t q_data,
	output logic          q_pop,
	input  logic [31:0]   max_allowed,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    result_kind,
	output logic [1:0]    status,
	output logic [3:0]    fired_index,
	output logic [31:0]   remaining_ticks,
	output logic          last
);
	import ate_pkg::*;

	typedef enum logic [2:0] {
		BK_IDLE   = 3'b001,
		BK_SCAN   = 3'b010,
		BK_FINISH = 3'b100
	} bk_state_t;

	bk_state_t        state_q;
	logic [IDX_W-1:0] scan_idx_q;
	tick_t            current_tick_q;
	tick_t            expiry_q [NUM_ALARMS];
	logic [31:0]      cycle_q  [NUM_ALARMS];
	logic             active_q [NUM_ALARMS];

	logic             out_valid_q;
	result_kind_t     result_kind_q;
	status_t          status_q;
	logic [3:0]       fired_index_q;
	logic [31:0]      remaining_q;
	logic             last_q;

	logic             can_emit;
	logic             take;
	logic             emit;
	logic [IDX_W-1:0] rd_addr;
	tick_t            rd_exp;
	logic [31:0]      rd_cyc;
	logic             rd_act;
	logic             hit;
	tick_t            reload_sum;
	tick_t            reload_exp;
	tick_t            set_rel_exp;
	tick_t            remain_diff;

	// result register frees up in the same cycle it is taken
	assign can_emit = !out_valid_q || out_ready;
	assign take     = (state_q == BK_IDLE) && !q_empty && can_emit;
	assign q_pop    = take;

	// a new result enters the output register this cycle
	assign emit = (take && (q_data.kind != CMD_TICK)) ||
	              ((state_q == BK_SCAN) && can_emit && hit) ||
	              ((state_q == BK_FINISH) && can_emit);

	// single read port: scan index during a tick, command slot otherwise
	assign rd_addr = (state_q == BK_SCAN) ? scan_idx_q : q_data.idx;
	assign rd_exp  = expiry_q[rd_addr];
	assign rd_cyc  = cycle_q[rd_addr];
	assign rd_act  = active_q[rd_addr];
	assign hit     = rd_act && !(current_tick_q < rd_exp);

	assign reload_sum  = TICK_WIDTH'(SUM_W'(current_tick_q) + SUM_W'(rd_cyc));
	// wrap past the counter peak
	assign reload_exp  = (CMP_W'(reload_sum) > CMP_W'(max_allowed)) ?
	                     reload_sum - TICK_WIDTH'(max_allowed) : reload_sum;
	assign set_rel_exp = TICK_WIDTH'(SUM_W'(current_tick_q) + SUM_W'(q_data.arg));
	assign remain_diff = rd_exp - current_tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BK_IDLE;
			scan_idx_q     <= '0;
			current_tick_q <= '0;
			for (int i = 0; i < NUM_ALARMS; i++) begin
				expiry_q[i] <= '0;
				cycle_q[i]  <= '0;
				active_q[i] <= 1'b0;
			end
			out_valid_q   <= 1'b0;
			result_kind_q <= RK_RESP;
			status_q      <= STS_OK;
			fired_index_q <= '0;
			remaining_q   <= '0;
			last_q        <= 1'b0;
		end else begin
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				BK_IDLE: begin
					if (take) begin
						if (q_data.kind == CMD_TICK) begin
							current_tick_q <= to_tick(q_data.arg);
							scan_idx_q     <= '0;
							state_q        <= BK_SCAN;
						end else begin
							result_kind_q <= RK_RESP;
							status_q      <= q_data.status;
							fired_index_q <= '0;
							remaining_q   <= '0;
							last_q        <= 1'b1;
							case (q_data.kind)
								CMD_SET_REL: begin
									expiry_q[q_data.idx] <= set_rel_exp;
									cycle_q[q_data.idx]  <= q_data.cycle;
									active_q[q_data.idx] <= 1'b1;
								end
								CMD_SET_ABS: begin
									expiry_q[q_data.idx] <= to_tick(q_data.arg);
									cycle_q[q_data.idx]  <= q_data.cycle;
									active_q[q_data.idx] <= 1'b1;
								end
								CMD_CANCEL: begin
									expiry_q[q_data.idx] <= '0;
									cycle_q[q_data.idx]  <= '0;
									active_q[q_data.idx] <= 1'b0;
								end
								CMD_QUERY: remaining_q <= 32'(remain_diff);
								default: ;
							endcase
						end
					end
				end
				BK_SCAN: begin
					if (can_emit) begin
						if (hit) begin
							result_kind_q <= RK_FIRE;
							status_q      <= STS_OK;
							fired_index_q <= 4'(scan_idx_q);
							remaining_q   <= '0;
							last_q        <= 1'b0;
							if (rd_cyc != '0) expiry_q[scan_idx_q] <= reload_exp;
							else active_q[scan_idx_q] <= 1'b0;
						end
						if (scan_idx_q == IDX_W'(NUM_ALARMS - 1)) state_q <= BK_FINISH;
						else scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				BK_FINISH: begin
					if (can_emit) begin
						result_kind_q <= RK_DONE;
						status_q      <= STS_OK;
						fired_index_q <= '0;
						remaining_q   <= '0;
						last_q        <= 1'b1;
						state_q       <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = result_kind_q;
	assign status          = status_q;
	assign fired_index     = fired_index_q;
	assign remaining_ticks = remaining_q;
	assign last            = last_q;

	`ATE_ASSERT_NOW(a_fire_not_last, (out_valid_q && result_kind_q == RK_FIRE), !last_q, "fire result marked last")
	`ATE_ASSERT_NEXT(a_done_emitted, (state_q == BK_FINISH && can_emit), (out_valid_q && result_kind_q == RK_DONE && last_q), "scan done result missing")
	`ATE_ASSERT_NEXT(a_scan_hold, (state_q == BK_SCAN && !can_emit), $stable(scan_idx_q), "scan moved while output stalled")

endmodule

// ===== rtl/alarm_table_expiry_core.sv =====
`timescale 1ns / 1ps
// top level of the alarm table: front end, command queue, back end
// depends on ate_pkg, ate_front, ate_cmd_fifo and ate_back
//
//  channel  handshake              payload
//  in       in_valid / in_ready    operation alarm_index tick_value time_value cycle_ticks
//  out      out_valid / out_ready  result_kind status fired_index remaining_ticks last
//  cfg      cfg_write              cfg_index cfg_data
//
// set, cancel, query and unknown ops: taken in the back end, one result each
// tick: one slot of the table visited per cycle while the output is not stalled, then done
// arst_n clears all slots, the current tick and the queue; configuration to defaults
// the two-entry command queue keeps taking items while the back end scans
// a stalled output holds the scan on its current slot
module alarm_table_expiry_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [ate_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    operation,
	input  logic [7:0]                    alarm_index,
	input  logic [31:0]                   tick_value,
	input  logic [31:0]                   time_value,
	input  logic [31:0]                   cycle_ticks,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    result_kind,
	output logic [1:0]                    status,
	output logic [3:0]                    fired_index,
	output logic [31:0]                   remaining_ticks,
	output logic                          last
);
	import ate_pkg::*;

	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	cmd_t        q_wr_data;
	cmd_t        q_rd_data;
	logic [31:0] max_allowed;

	ate_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.alarm_index (alarm_index),
		.tick_value  (tick_value),
		.time_value  (time_value),
		.cycle_ticks (cycle_ticks),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wr_data),
		.max_allowed (max_allowed)
	);

	ate_cmd_fifo u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wr_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rd_data),
		.empty     (q_empty)
	);

	ate_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_data          (q_rd_data),
		.q_pop           (q_pop),
		.max_allowed     (max_allowed),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_kind     (result_kind),
		.status          (status),
		.fired_index     (fired_index),
		.remaining_ticks (remaining_ticks),
		.last            (last)
	);

endmodule
